>>> src/goldbach_pair_finder_macros.svh
// ----------------------------------------------------------------------------
// goldbach pair finder assertion macros
// shared property forms for the checker, clocked and gated by reset
// ----------------------------------------------------------------------------
`ifndef GOLDBACH_PAIR_FINDER_MACROS_SVH
`define GOLDBACH_PAIR_FINDER_MACROS_SVH

// same-cycle implication
`define GPF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpf check failed: same-cycle implication");

// next-cycle implication
`define GPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpf check failed: next-cycle implication");

`endif

>>> src/gpf_pkg.sv
// ----------------------------------------------------------------------------
// gpf_pkg
// types, constants and the microprogram of the goldbach pair finder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpf_pkg;

    // fixed field widths
    localparam int TGW = 16;
    localparam int LPW = 11;
    localparam int SPW = 10;

    // number constants of the algorithm
    localparam int SMALLEST_PRIME  = 2;
    localparam int FIRST_ODD_PRIME = 3;
    localparam int MIN_TARGET      = 4;

    // step counter width
    localparam int PCW = 5;

    // datapath actions, one per control word
    typedef enum logic [4:0] {
        OP_NONE,
        OP_IDLE,
        OP_CLR_INIT,
        OP_CLR_WR,
        OP_SV_INIT,
        OP_SQ,
        OP_J_INIT,
        OP_MARK,
        OP_INC_I,
        OP_SC_INIT,
        OP_RD_P,
        OP_RD_Q,
        OP_EMIT_PEND,
        OP_LOAD_PEND,
        OP_ADV,
        OP_SET_MORE,
        OP_LOAD_FOUR,
        OP_EMIT_LAST,
        OP_EMIT_ERR
    } t_op;

    // jump conditions
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_IN,
        C_BAD,
        C_CLR_MORE,
        C_FOUR,
        C_SQ_GE_N,
        C_RD_SET,
        C_J_MORE,
        C_P_DONE,
        C_COMP,
        C_FULL,
        C_OUT_WAIT
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PCW-1:0]  target;
    } t_uword;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic bad;
        logic four;
        logic clr_more;
        logic sq_ge_n;
        logic rd_set;
        logic j_more;
        logic p_done;
        logic comp;
        logic full;
        logic out_wait;
    } t_flags;

    // step addresses
    localparam logic [PCW-1:0] A_IDLE      = 5'd0;
    localparam logic [PCW-1:0] A_CHECK     = 5'd1;
    localparam logic [PCW-1:0] A_CLR_INIT  = 5'd2;
    localparam logic [PCW-1:0] A_CLR       = 5'd3;
    localparam logic [PCW-1:0] A_FOUR_CHK  = 5'd4;
    localparam logic [PCW-1:0] A_SV_INIT   = 5'd5;
    localparam logic [PCW-1:0] A_SQ        = 5'd6;
    localparam logic [PCW-1:0] A_SQ_CHK    = 5'd7;
    localparam logic [PCW-1:0] A_PRIME_CHK = 5'd8;
    localparam logic [PCW-1:0] A_J_INIT    = 5'd9;
    localparam logic [PCW-1:0] A_MARK      = 5'd10;
    localparam logic [PCW-1:0] A_NEXT_I    = 5'd11;
    localparam logic [PCW-1:0] A_SC_INIT   = 5'd12;
    localparam logic [PCW-1:0] A_RD_P      = 5'd13;
    localparam logic [PCW-1:0] A_RD_Q      = 5'd14;
    localparam logic [PCW-1:0] A_PAIR_CHK  = 5'd15;
    localparam logic [PCW-1:0] A_FULL_CHK  = 5'd16;
    localparam logic [PCW-1:0] A_EMIT      = 5'd17;
    localparam logic [PCW-1:0] A_LOAD      = 5'd18;
    localparam logic [PCW-1:0] A_ADV       = 5'd19;
    localparam logic [PCW-1:0] A_TRUNC     = 5'd20;
    localparam logic [PCW-1:0] A_FOUR      = 5'd21;
    localparam logic [PCW-1:0] A_FINISH    = 5'd22;
    localparam logic [PCW-1:0] A_DONE      = 5'd23;
    localparam logic [PCW-1:0] A_ERR       = 5'd24;
    localparam logic [PCW-1:0] A_ERR_DONE  = 5'd25;

    // microprogram rom: jump to target when cond holds, else fall through
    function automatic t_uword ucode(input logic [PCW-1:0] addr);
        t_uword w;
        case (addr)
            A_IDLE:      w = '{OP_IDLE,      C_NO_IN,    A_IDLE};
            A_CHECK:     w = '{OP_NONE,      C_BAD,      A_ERR};
            A_CLR_INIT:  w = '{OP_CLR_INIT,  C_NONE,     A_IDLE};
            A_CLR:       w = '{OP_CLR_WR,    C_CLR_MORE, A_CLR};
            A_FOUR_CHK:  w = '{OP_NONE,      C_FOUR,     A_FOUR};
            A_SV_INIT:   w = '{OP_SV_INIT,   C_NONE,     A_IDLE};
            A_SQ:        w = '{OP_SQ,        C_NONE,     A_IDLE};
            A_SQ_CHK:    w = '{OP_NONE,      C_SQ_GE_N,  A_SC_INIT};
            A_PRIME_CHK: w = '{OP_NONE,      C_RD_SET,   A_NEXT_I};
            A_J_INIT:    w = '{OP_J_INIT,    C_NONE,     A_IDLE};
            A_MARK:      w = '{OP_MARK,      C_J_MORE,   A_MARK};
            A_NEXT_I:    w = '{OP_INC_I,     C_ALWAYS,   A_SQ};
            A_SC_INIT:   w = '{OP_SC_INIT,   C_NONE,     A_IDLE};
            A_RD_P:      w = '{OP_RD_P,      C_P_DONE,   A_FINISH};
            A_RD_Q:      w = '{OP_RD_Q,      C_NONE,     A_IDLE};
            A_PAIR_CHK:  w = '{OP_NONE,      C_COMP,     A_ADV};
            A_FULL_CHK:  w = '{OP_NONE,      C_FULL,     A_TRUNC};
            A_EMIT:      w = '{OP_EMIT_PEND, C_OUT_WAIT, A_EMIT};
            A_LOAD:      w = '{OP_LOAD_PEND, C_NONE,     A_IDLE};
            A_ADV:       w = '{OP_ADV,       C_ALWAYS,   A_RD_P};
            A_TRUNC:     w = '{OP_SET_MORE,  C_ALWAYS,   A_FINISH};
            A_FOUR:      w = '{OP_LOAD_FOUR, C_ALWAYS,   A_FINISH};
            A_FINISH:    w = '{OP_EMIT_LAST, C_OUT_WAIT, A_FINISH};
            A_DONE:      w = '{OP_NONE,      C_ALWAYS,   A_IDLE};
            A_ERR:       w = '{OP_EMIT_ERR,  C_OUT_WAIT, A_ERR};
            A_ERR_DONE:  w = '{OP_NONE,      C_ALWAYS,   A_IDLE};
            default:     w = '{OP_NONE,      C_ALWAYS,   A_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/gpf_ram.sv
// ----------------------------------------------------------------------------
// gpf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/gpf_seq.sv
// ----------------------------------------------------------------------------
// gpf_seq
// step counter and microprogram rom with conditional jumps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpf_seq
    import gpf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_flags i_flags,
    output t_uword      o_uword,
    output logic        o_busy
);

    logic [PCW-1:0] r_pc;
    logic [PCW-1:0] n_pc;
    t_uword         uword;
    logic           take;

    // fetch the current control word
    assign uword = ucode(r_pc);

    // condition select
    always_comb begin
        case (uword.cond)
            C_NONE:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !i_valid;
            C_BAD:      take = i_flags.bad;
            C_CLR_MORE: take = i_flags.clr_more;
            C_FOUR:     take = i_flags.four;
            C_SQ_GE_N:  take = i_flags.sq_ge_n;
            C_RD_SET:   take = i_flags.rd_set;
            C_J_MORE:   take = i_flags.j_more;
            C_P_DONE:   take = i_flags.p_done;
            C_COMP:     take = i_flags.comp;
            C_FULL:     take = i_flags.full;
            C_OUT_WAIT: take = i_flags.out_wait;
            default:    take = 1'b0;
        endcase
        n_pc = take ? uword.target : r_pc + PCW'(1);
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uword;
    assign o_busy  = (r_pc != A_IDLE);

endmodule

`default_nettype wire

>>> src/gpf_dp.sv
// ----------------------------------------------------------------------------
// gpf_dp
// sieve datapath: counters, squarer, composite map and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpf_dp
    import gpf_pkg::*;
#(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_PAIRS  = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [TGW-1:0] i_target,
    input  wire t_uword         i_uword,
    output t_flags              o_flags,
    input  wire logic           i_stall,
    output logic                o_valid,
    output logic [LPW-1:0]      o_larger_prime,
    output logic [SPW-1:0]      o_smaller_prime,
    output logic                o_status,
    output logic                o_truncated,
    output logic                o_last
);

    localparam int NW    = $clog2(MAX_TARGET + 1);
    localparam int JW    = NW + 1;
    localparam int SQW   = 2 * NW;
    localparam int DEPTH = MAX_TARGET / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_PAIRS + 1);

    // working registers
    logic [NW-1:0]  r_n,      n_n;
    logic           r_bad,    n_bad;
    logic [NW-1:0]  r_i,      n_i;
    logic [JW-1:0]  r_j,      n_j;
    logic [SQW-1:0] r_sq,     n_sq;
    logic [CW-1:0]  r_cnt,    n_cnt;
    logic           r_more,   n_more;
    logic           r_pflag,  n_pflag;
    logic           r_pend_v, n_pend_v;
    logic [LPW-1:0] r_pend_l, n_pend_l;
    logic [SPW-1:0] r_pend_s, n_pend_s;

    // result register
    logic           r_ovalid,   n_ovalid;
    logic [LPW-1:0] r_olarger,  n_olarger;
    logic [SPW-1:0] r_osmaller, n_osmaller;
    logic           r_ostatus,  n_ostatus;
    logic           r_otrunc,   n_otrunc;
    logic           r_olast,    n_olast;

    // map port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    // emit request
    logic           emit_req;
    logic [LPW-1:0] emit_l;
    logic [SPW-1:0] emit_s;
    logic           emit_status;
    logic           emit_trunc;
    logic           emit_last;
    logic           slot_free;
    logic           emit_fire;

    logic [JW-1:0]  j_step;
    logic [JW:0]    j_inc;

    gpf_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next multiple of the current prime, odd multiples only
    assign j_step = r_j + {r_i, 1'b0};
    assign j_inc  = {1'b0, r_j} + (JW + 1)'(1);

    assign slot_free = !r_ovalid || !i_stall;
    assign emit_fire = emit_req && slot_free;

    // datapath actions
    always_comb begin
        n_n      = r_n;
        n_bad    = r_bad;
        n_i      = r_i;
        n_j      = r_j;
        n_sq     = r_sq;
        n_cnt    = r_cnt;
        n_more   = r_more;
        n_pflag  = r_pflag;
        n_pend_v = r_pend_v;
        n_pend_l = r_pend_l;
        n_pend_s = r_pend_s;

        ram_we    = 1'b0;
        ram_waddr = r_j[AW-1:0];
        ram_wdata = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_i[AW:1];

        emit_req    = 1'b0;
        emit_l      = r_pend_l;
        emit_s      = r_pend_s;
        emit_status = 1'b0;
        emit_trunc  = 1'b0;
        emit_last   = 1'b0;

        case (i_uword.op)
            OP_IDLE: begin
                if (i_valid) begin
                    n_n   = NW'(i_target);
                    n_bad = i_target[0] || (i_target < TGW'(MIN_TARGET))
                            || ({16'd0, i_target} > 32'(MAX_TARGET));
                end
            end
            OP_CLR_INIT: begin
                n_j      = '0;
                n_cnt    = '0;
                n_more   = 1'b0;
                n_pend_v = 1'b0;
            end
            OP_CLR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = 1'b0;
                n_j       = r_j + JW'(1);
            end
            OP_SV_INIT: begin
                n_i = NW'(FIRST_ODD_PRIME);
            end
            OP_SQ: begin
                n_sq      = SQW'(r_i) * SQW'(r_i);
                ram_re    = 1'b1;
                ram_raddr = r_i[AW:1];
            end
            OP_J_INIT: begin
                n_j = JW'(r_sq);
            end
            OP_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AW:1];
                ram_wdata = 1'b1;
                n_j       = j_step;
            end
            OP_INC_I: begin
                n_i = r_i + NW'(2);
            end
            OP_SC_INIT: begin
                n_i = NW'(FIRST_ODD_PRIME);
                n_j = JW'(r_n) - JW'(FIRST_ODD_PRIME);
            end
            OP_RD_P: begin
                ram_re    = 1'b1;
                ram_raddr = r_i[AW:1];
            end
            OP_RD_Q: begin
                n_pflag   = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = r_j[AW:1];
            end
            OP_EMIT_PEND: begin
                emit_req = r_pend_v;
            end
            OP_LOAD_PEND: begin
                n_pend_v = 1'b1;
                n_pend_l = LPW'(r_j);
                n_pend_s = SPW'(r_i);
                n_cnt    = r_cnt + CW'(1);
            end
            OP_ADV: begin
                n_i = r_i + NW'(2);
                n_j = r_j - JW'(2);
            end
            OP_SET_MORE: begin
                n_more = 1'b1;
            end
            OP_LOAD_FOUR: begin
                n_pend_v = 1'b1;
                n_pend_l = LPW'(SMALLEST_PRIME);
                n_pend_s = SPW'(SMALLEST_PRIME);
                n_cnt    = CW'(1);
            end
            OP_EMIT_LAST: begin
                emit_req   = r_pend_v;
                emit_trunc = r_more;
                emit_last  = 1'b1;
            end
            OP_EMIT_ERR: begin
                emit_req    = 1'b1;
                emit_l      = '0;
                emit_s      = '0;
                emit_status = 1'b1;
                emit_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result register, loaded only when the slot is free
    always_comb begin
        n_ovalid   = r_ovalid;
        n_olarger  = r_olarger;
        n_osmaller = r_osmaller;
        n_ostatus  = r_ostatus;
        n_otrunc   = r_otrunc;
        n_olast    = r_olast;
        if (emit_fire) begin
            n_ovalid   = 1'b1;
            n_olarger  = emit_l;
            n_osmaller = emit_s;
            n_ostatus  = emit_status;
            n_otrunc   = emit_trunc;
            n_olast    = emit_last;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_more   <= 1'b0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_more   <= n_more;
            r_pend_v <= n_pend_v;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_bad      <= n_bad;
        r_i        <= n_i;
        r_j        <= n_j;
        r_sq       <= n_sq;
        r_pflag    <= n_pflag;
        r_pend_l   <= n_pend_l;
        r_pend_s   <= n_pend_s;
        r_olarger  <= n_olarger;
        r_osmaller <= n_osmaller;
        r_ostatus  <= n_ostatus;
        r_otrunc   <= n_otrunc;
        r_olast    <= n_olast;
    end

    // status for the sequencer
    always_comb begin
        o_flags.bad      = r_bad;
        o_flags.four     = (r_n == NW'(MIN_TARGET));
        o_flags.clr_more = (j_inc < (JW + 1)'(r_n >> 1));
        o_flags.sq_ge_n  = (r_sq >= SQW'(r_n));
        o_flags.rd_set   = ram_rdata;
        o_flags.j_more   = (j_step < JW'(r_n));
        o_flags.p_done   = (r_i > (r_n >> 1));
        o_flags.comp     = r_pflag || ram_rdata;
        o_flags.full     = (r_cnt == CW'(MAX_PAIRS));
        o_flags.out_wait = emit_req && !slot_free;
    end

    assign o_valid         = r_ovalid;
    assign o_larger_prime  = r_olarger;
    assign o_smaller_prime = r_osmaller;
    assign o_status        = r_ostatus;
    assign o_truncated     = r_otrunc;
    assign o_last          = r_olast;

endmodule

`default_nettype wire

>>> src/goldbach_pair_finder.sv
// ----------------------------------------------------------------------------
// goldbach_pair_finder
// splits an even target into prime pairs with a microcoded sieve
//
//   channel  direction  handshake          payload
//   request  in         i_valid / o_stall  i_target
//   result   out        o_valid / i_stall  o_larger_prime, o_smaller_prime,
//                                          o_status, o_truncated, o_last
//
// one request at a time; o_stall is high from acceptance until the sequencer has left its
// done step after the last result of the request has gone into the output register
// target n: the map is cleared, each odd sieve base is squared and looked up, each prime
// marks its odd multiples, then every odd p up to n/2 is read with n - p and each pair
// is emitted; an invalid target goes straight to the error result; synchronous reset,
// no clearing pass as every valid request clears the map
// a stalled output holds the sequencer at its emit step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module goldbach_pair_finder
    import gpf_pkg::*;
#(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_PAIRS  = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [TGW-1:0] i_target,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [LPW-1:0]      o_larger_prime,
    output logic [SPW-1:0]      o_smaller_prime,
    output logic                o_status,
    output logic                o_truncated,
    output logic                o_last
);

    t_uword uword;
    t_flags flags;
    logic   busy;

    // sequencer
    gpf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_flags (flags),
        .o_uword (uword),
        .o_busy  (busy)
    );

    // datapath
    gpf_dp #(
        .MAX_TARGET (MAX_TARGET),
        .MAX_PAIRS  (MAX_PAIRS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_target        (i_target),
        .i_uword         (uword),
        .o_flags         (flags),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_larger_prime  (o_larger_prime),
        .o_smaller_prime (o_smaller_prime),
        .o_status        (o_status),
        .o_truncated     (o_truncated),
        .o_last          (o_last)
    );

    assign o_stall = busy;

endmodule

`default_nettype wire

>>> src/gpf_checker.sv
// ----------------------------------------------------------------------------
// gpf_checker
// port-level checks on the goldbach pair finder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "goldbach_pair_finder_macros.svh"

module gpf_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_stall,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [10:0] o_larger_prime,
    input  wire logic [9:0]  o_smaller_prime,
    input  wire logic        o_status,
    input  wire logic        o_truncated,
    input  wire logic        o_last
);

    // an accepted item keeps the block busy
    `GPF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // error result carries no primes and closes the request
    `GPF_ASSERT_IMPLY(a_error_shape, i_clk, i_rst_n, o_valid && o_status, o_larger_prime == 11'd0 && o_smaller_prime == 10'd0 && o_last && !o_truncated)

    // truncation is only flagged on the closing pair
    `GPF_ASSERT_IMPLY(a_trunc_on_last, i_clk, i_rst_n, o_valid && o_truncated, o_last && !o_status)

    // a stalled result holds
    `GPF_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_larger_prime) && $stable(o_smaller_prime) && $stable(o_last))

endmodule

bind goldbach_pair_finder gpf_checker u_gpf_checker (.*);

`default_nettype wire

>>> verif/goldbach_pair_finder_tb.sv
// ----------------------------------------------------------------------------
// goldbach_pair_finder_tb
// drives even, odd and out-of-range targets into the pair finder with random
// gaps on both channels; a scoreboard sieves each accepted target itself and
// checks every result field by field against the pairs it expects
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module goldbach_pair_finder_tb;
    import gpf_pkg::*;

    localparam int TB_MAX_TARGET  = 1024;
    localparam int TB_MAX_PAIRS   = 64;
    localparam int RANDOM_ITEMS   = 120;
    localparam int CHUNK_ITEMS    = 20;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    // result status codes
    localparam logic ST_PAIR = 1'b0;
    localparam logic ST_BAD  = 1'b1;

    typedef struct packed {
        logic [LPW-1:0] larger;
        logic [SPW-1:0] smaller;
        logic           status;
        logic           truncated;
        logic           last;
    } t_split;

    // expected pairs per target and the comparison against the block
    class pair_ledger;
        t_split      expected_pairs[$];
        bit          composite[TB_MAX_TARGET];
        logic [6:0]  pairs_emitted;
        int          mismatches;

        function new();
            foreach (composite[k]) composite[k] = 1'b0;
            pairs_emitted = '0;
            mismatches    = 0;
        endfunction

        // sieve the target and queue every pair it splits into
        function void note_target(logic [TGW-1:0] target);
            int     n;
            int     i;
            int     j;
            int     p;
            bit     more;
            t_split r;
            t_split found[$];
            n    = int'(target);
            more = 1'b0;
            // invalid target gives a single error item
            if (n % 2 != 0 || n < MIN_TARGET || n > TB_MAX_TARGET) begin
                pairs_emitted = '0;
                r = '{larger: '0, smaller: '0, status: ST_BAD, truncated: 1'b0,
                      last: 1'b1};
                expected_pairs = {expected_pairs, r};
                return;
            end
            foreach (composite[k]) composite[k] = 1'b0;
            // four is the only target split by the even prime
            if (n == MIN_TARGET) begin
                pairs_emitted = 7'd1;
                r = '{larger: LPW'(SMALLEST_PRIME), smaller: SPW'(SMALLEST_PRIME),
                      status: ST_PAIR, truncated: 1'b0, last: 1'b1};
                expected_pairs = {expected_pairs, r};
                return;
            end
            // mark odd composites below the target
            for (i = FIRST_ODD_PRIME; i * i < n; i += 2) begin
                if (!composite[i]) begin
                    for (j = i * i; j < n; j += i) composite[j] = 1'b1;
                end
            end
            // walk odd primes up to half the target
            for (p = FIRST_ODD_PRIME; p <= n / 2; p += 2) begin
                if (composite[p] || composite[n - p]) continue;
                if (found.size() >= TB_MAX_PAIRS) begin
                    more = 1'b1;
                    break;
                end
                r = '{larger: LPW'(n - p), smaller: SPW'(p), status: ST_PAIR,
                      truncated: 1'b0, last: 1'b0};
                found = {found, r};
            end
            if (found.size() > 0) begin
                found[found.size() - 1].truncated = more;
                found[found.size() - 1].last      = 1'b1;
            end
            pairs_emitted = 7'(found.size());
            foreach (found[k]) expected_pairs = {expected_pairs, found[k]};
        endfunction

        // compare one accepted result with the oldest expected pair
        function void check_pair(t_split got);
            t_split want;
            if (expected_pairs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: l=%0d s=%0d st=%0d tr=%0d last=%0d",
                             got.larger, got.smaller, got.status, got.truncated,
                             got.last);
                return;
            end
            want = expected_pairs.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch: expected l=%0d s=%0d st=%0d tr=%0d last=%0d,",
                           want.larger, want.smaller, want.status, want.truncated,
                           want.last);
                    $display(" got l=%0d s=%0d st=%0d tr=%0d last=%0d",
                             got.larger, got.smaller, got.status, got.truncated,
                             got.last);
                end
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic [TGW-1:0] i_target = '0;
    logic           i_stall = 1'b0;
    logic           o_stall;
    logic           o_valid;
    logic [LPW-1:0] o_larger_prime;
    logic [SPW-1:0] o_smaller_prime;
    logic           o_status;
    logic           o_truncated;
    logic           o_last;

    pair_ledger ledger = new();
    int         tx_gap_max = 5;
    int         rx_gap_max = 5;
    int         rx_hold = 0;
    int         idle_cycles = 0;

    goldbach_pair_finder #(
        .MAX_TARGET (TB_MAX_TARGET),
        .MAX_PAIRS  (TB_MAX_PAIRS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_target        (i_target),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_larger_prime  (o_larger_prime),
        .o_smaller_prime (o_smaller_prime),
        .o_status        (o_status),
        .o_truncated     (o_truncated),
        .o_last          (o_last)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hand one target over, called at a falling edge
    task automatic send_target(input logic [TGW-1:0] target);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_target = target;
        do @(posedge i_clk); while (o_stall);
        ledger.note_target(target);
        @(negedge i_clk);
    endtask

    // mostly small even targets, some large, odd, tiny and wide ones
    function automatic logic [TGW-1:0] draw_target();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 60)
            return TGW'(2 * $urandom_range(100, 2));
        else if (pick < 72)
            return TGW'(2 * $urandom_range(TB_MAX_TARGET / 2, 2));
        else if (pick < 86)
            return TGW'(2 * $urandom_range(TB_MAX_TARGET / 2 - 1, 0) + 1);
        else if (pick < 90)
            return TGW'($urandom_range(MIN_TARGET - 1, 0));
        else
            return TGW'($urandom_range(16'hFFFF, 0));
    endfunction

    // receiver stall, reloaded after every accepted result
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_stall = 1'b1;
            rx_hold = rx_hold - 1;
        end else begin
            i_stall = 1'b0;
        end
    end

    // result capture
    always @(posedge i_clk) begin
        t_split got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{larger: o_larger_prime, smaller: o_smaller_prime, status: o_status,
                    truncated: o_truncated, last: o_last};
            ledger.check_pair(got);
            rx_hold = $urandom_range(rx_gap_max, 0);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin
        logic [TGW-1:0] directed[$];
        int             sent;
        directed = '{16'd4, 16'd6, 16'd8, 16'd10, 16'd12, 16'd0, 16'd1, 16'd2,
                     16'd3, 16'd5, 16'd1023, 16'd1024, 16'd1022, 16'd1026,
                     16'd1025, 16'hFFFF, 16'hFFFE, 16'h8000, 16'h5555,
                     16'hAAAA, 16'd98, 16'd128, 16'd210, 16'd1000};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed corners: extremes, four, odd, below range and above range
        foreach (directed[k]) send_target(directed[k]);

        // random chunks, some of them with no idling at all
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(3, 0) == 0) begin
                tx_gap_max = 0;
                rx_gap_max = 0;
            end else begin
                tx_gap_max = 5;
                rx_gap_max = 5;
            end
            repeat (CHUNK_ITEMS) begin
                send_target(draw_target());
                sent++;
            end
        end
        i_valid = 1'b0;

        // drain outstanding pairs, the watchdog bounds this wait
        while (ledger.expected_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.mismatches == 0 && ledger.expected_pairs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
